/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* hw/rtl/gdpg_pkg.sv */
// ---------------------------------------------------------------------------
// gdpg_pkg
// Constants, types and the exp(-x) table of the derivative pulse generator.
// ---------------------------------------------------------------------------
`default_nettype none

package gdpg_pkg;

  localparam int FracBits = 16;
  localparam int ExpDepth = 256;
  localparam int ExpAw    = $clog2(ExpDepth);
  localparam int ExpW     = 31;

  localparam int TimeW = 32;
  localparam int AmpW  = 32;
  localparam int FreqW = 24;
  localparam int OutW  = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [31:0] PiQ30 = 32'd3373259426;

  localparam int PfW   = FreqW + 2;
  localparam int UmagW = FracBits + 2;
  localparam int XW    = FracBits + 4;
  localparam int MW    = UmagW + ExpW + 1 - 30;
  localparam int YW    = MW + AmpW + 1 - FracBits;

  localparam int NumStages = 8;

  localparam longint unsigned ExpStep = (64'd1 << 34) / ExpDepth;

  typedef enum logic [CfgIdxW-1:0] {
    RegAmplitude  = 3'd0,
    RegStartTime  = 3'd1,
    RegFinishTime = 3'd2,
    RegPeakDelay  = 3'd3,
    RegFrequency  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic win;
    logic zero;
    logic neg;
  } ctl_t;

  typedef logic [ExpW-1:0] exp_tab_t [ExpDepth+1];

  // Shift-and-subtract quotient, used only while building the table.
  function automatic longint unsigned div_small(longint unsigned num, int unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= 64'(den)) begin
        rem    = rem - 64'(den);
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t        tab;
    longint unsigned h;
    longint unsigned term;
    longint unsigned r;
    longint unsigned prod;
    longint          sum;
    h    = ExpStep;
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    for (int k = 1; k <= 12; k++) begin
      term = div_small((term * h) >> 30, unsigned'(k));
      if (k[0] == 1'b1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    r = (sum < 0) ? 64'd0 : longint'(unsigned'(sum));
    tab[0] = ExpW'(64'd1 << 30);
    for (int i = 1; i <= ExpDepth; i++) begin
      prod   = 64'(tab[i-1]) * r + (64'd1 << 29);
      tab[i] = ExpW'(prod >> 30);
    end
    return tab;
  endfunction

  localparam exp_tab_t ExpTab = build_exp_tab();

endpackage

`default_nettype wire

/* hw/rtl/gaussian_derivative_pulse_generator.sv */
// Throughput: one sample per cycle unless m_axis_tready_i stalls the output;
// each of the eight register stages holds one item and advances whenever the
// stage after it is empty or moving.
// Reset clears all stage valid bits and loads the configuration registers with
// their reset values; the exp table is constant logic and needs no clearing.
// ---------------------------------------------------------------------------
// gaussian_derivative_pulse_generator
// Streams amplitude * u * exp(-u*u) for sample times inside a time window.
// ---------------------------------------------------------------------------
`default_nettype none

module gaussian_derivative_pulse_generator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [gdpg_pkg::TimeW-1:0]      s_axis_tdata_i,   // [31:0] sample_time
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic signed [gdpg_pkg::OutW-1:0]     m_axis_tdata_o,   // [31:0] wave_value
  output logic [0:0]                           m_axis_tuser_o,   // [0] in_window
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [gdpg_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [gdpg_pkg::CfgDataW-1:0]   cfg_data_i
);
  import gdpg_pkg::*;

  localparam int ProdUW = PfW + TimeW + 1;
  localparam int SqW    = 2 * UmagW + 1;
  localparam int PosW   = XW + ExpAw;
  localparam int CpW    = ExpW + XW;
  localparam int MpW    = UmagW + ExpW + 1;
  localparam int YpW    = MW + AmpW + 1;
  localparam int PiPW   = TimeW + FreqW + 1;

  logic [AmpW-1:0]  amp_q;
  logic [TimeW-1:0] start_q;
  logic [TimeW-1:0] finish_q;
  logic [TimeW-1:0] delay_q;
  logic [FreqW-1:0] freq_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q    <= AmpW'(65536);
      start_q  <= '0;
      finish_q <= '0;
      delay_q  <= '0;
      freq_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegAmplitude:  amp_q    <= cfg_data_i[AmpW-1:0];
        RegStartTime:  start_q  <= cfg_data_i[TimeW-1:0];
        RegFinishTime: finish_q <= cfg_data_i[TimeW-1:0];
        RegPeakDelay:  delay_q  <= cfg_data_i[TimeW-1:0];
        RegFrequency:  freq_q   <= cfg_data_i[FreqW-1:0];
        default: ;
      endcase
    end
  end

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || m_axis_tready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready_o = en[0];

  // Stage 0: window test, offset from the pulse center, pi * f
  logic [TimeW:0]   s0_origin;
  logic             s0_win;
  logic             s0_dneg;
  logic [TimeW:0]   s0_dwide;
  logic [PiPW-1:0]  s0_pip;
  logic             s0_win_q;
  logic             s0_dneg_q;
  logic [TimeW-1:0] s0_dmag_q;
  logic [PfW-1:0]   s0_pf_q;

  always_comb begin
    s0_win    = (s_axis_tdata_i >= start_q) && (s_axis_tdata_i <= finish_q);
    s0_origin = (TimeW+1)'(start_q) + (TimeW+1)'(delay_q);
    s0_dneg   = (TimeW+1)'(s_axis_tdata_i) < s0_origin;
    s0_dwide  = s0_dneg ? (s0_origin - (TimeW+1)'(s_axis_tdata_i))
                        : ((TimeW+1)'(s_axis_tdata_i) - s0_origin);
    s0_pip    = PiPW'(PiQ30) * PiPW'(freq_q) + PiPW'(64'd1 << 29);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_win_q  <= s0_win;
      s0_dneg_q <= s0_dneg;
      s0_dmag_q <= s0_dwide[TimeW-1:0];
      s0_pf_q   <= s0_pip[30 +: PfW];
    end
  end

  // Stage 1: |u| = round(pf * |d|)
  logic [ProdUW-1:0] s1_prod;
  ctl_t              s1_ctl_q;
  logic [UmagW-1:0]  s1_umag_q;

  assign s1_prod = ProdUW'(s0_pf_q) * ProdUW'(s0_dmag_q) + ProdUW'(64'd1 << (FracBits - 1));

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_ctl_q  <= '{win:  s0_win_q,
                     zero: !s0_win_q || (|s1_prod[ProdUW-1:FracBits+UmagW]),
                     neg:  s0_dneg_q};
      s1_umag_q <= s1_prod[FracBits +: UmagW];
    end
  end

  // Stage 2: x = round(u * u)
  logic [SqW-1:0]   s2_sq;
  ctl_t             s2_ctl_q;
  logic [UmagW-1:0] s2_umag_q;
  logic [XW-1:0]    s2_x_q;

  assign s2_sq = SqW'(s1_umag_q) * SqW'(s1_umag_q) + SqW'(64'd1 << (FracBits - 1));

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_ctl_q  <= '{win:  s1_ctl_q.win,
                     zero: s1_ctl_q.zero || s2_sq[FracBits+XW],
                     neg:  s1_ctl_q.neg};
      s2_umag_q <= s1_umag_q;
      s2_x_q    <= s2_sq[FracBits +: XW];
    end
  end

  // Stage 3: table lookup of the two neighbor points
  logic [PosW-1:0]  s3_pos;
  logic [ExpAw-1:0] s3_idx;
  logic [ExpW-1:0]  s3_ta;
  logic [ExpW-1:0]  s3_tb;
  ctl_t             s3_ctl_q;
  logic [UmagW-1:0] s3_umag_q;
  logic [ExpW-1:0]  s3_a_q;
  logic [ExpW-1:0]  s3_diff_q;
  logic [XW-1:0]    s3_frac_q;

  always_comb begin
    s3_pos = {s2_x_q, {ExpAw{1'b0}}};
    s3_idx = s3_pos[PosW-1:XW];
    s3_ta  = ExpTab[(ExpAw+1)'(s3_idx)];
    s3_tb  = ExpTab[(ExpAw+1)'(s3_idx) + (ExpAw+1)'(1)];
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_ctl_q  <= s2_ctl_q;
      s3_umag_q <= s2_umag_q;
      s3_a_q    <= s3_ta;
      s3_diff_q <= s3_ta - s3_tb;
      s3_frac_q <= s3_pos[XW-1:0];
    end
  end

  // Stage 4: interpolate e = a - (a - b) * frac
  logic [CpW-1:0]   s4_cp;
  ctl_t             s4_ctl_q;
  logic [UmagW-1:0] s4_umag_q;
  logic [ExpW-1:0]  s4_e_q;

  assign s4_cp = CpW'(s3_diff_q) * CpW'(s3_frac_q);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_ctl_q  <= s3_ctl_q;
      s4_umag_q <= s3_umag_q;
      s4_e_q    <= s3_a_q - s4_cp[CpW-1:XW];
    end
  end

  // Stage 5: m = round(|u| * e)
  logic [MpW-1:0] s5_mp;
  ctl_t           s5_ctl_q;
  logic [MW-1:0]  s5_m_q;

  assign s5_mp = MpW'(s4_umag_q) * MpW'(s4_e_q) + MpW'(64'd1 << 29);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_ctl_q <= s4_ctl_q;
      s5_m_q   <= s5_mp[MpW-1:30];
    end
  end

  // Stage 6: |y| = round(m * |amplitude|)
  logic            s6_aneg;
  logic [AmpW-1:0] s6_amag;
  logic [YpW-1:0]  s6_yp;
  ctl_t            s6_ctl_q;
  logic [YW-1:0]   s6_ymag_q;

  always_comb begin
    s6_aneg = amp_q[AmpW-1];
    s6_amag = s6_aneg ? (~amp_q + AmpW'(1)) : amp_q;
    s6_yp   = YpW'(s5_m_q) * YpW'(s6_amag) + YpW'(64'd1 << (FracBits - 1));
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_ctl_q  <= '{win:  s5_ctl_q.win,
                     zero: s5_ctl_q.zero,
                     neg:  s5_ctl_q.neg ^ s6_aneg};
      s6_ymag_q <= s6_yp[YpW-1:FracBits];
    end
  end

  // Stage 7: sign, saturate, output register
  logic [OutW-1:0] s7_mag;
  logic [OutW-1:0] s7_res;
  logic [OutW-1:0] out_data_q;
  logic            out_win_q;

  always_comb begin
    if (s6_ctl_q.neg) begin
      s7_mag = ((|s6_ymag_q[YW-1:OutW]) || (s6_ymag_q[OutW-1] && (|s6_ymag_q[OutW-2:0])))
               ? {1'b1, {(OutW-1){1'b0}}} : s6_ymag_q[OutW-1:0];
      s7_res = ~s7_mag + OutW'(1);
    end else begin
      s7_mag = '0;
      s7_res = (|s6_ymag_q[YW-1:OutW-1]) ? {1'b0, {(OutW-1){1'b1}}}
                                         : s6_ymag_q[OutW-1:0];
    end
    if (s6_ctl_q.zero) begin
      s7_res = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      out_data_q <= s7_res;
      out_win_q  <= s6_ctl_q.win;
    end
  end

  assign m_axis_tvalid_o = v_q[NumStages-1];
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_win_q;

endmodule

`default_nettype wire

/* hw/rtl/gdpg_checker.sv */
// ---------------------------------------------------------------------------
// gdpg_checker
// Port-level checks of the derivative pulse generator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gdpg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic [0:0]  m_axis_tuser_o
);

  `ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid_o)

  `ASSERT_CLK(a_result_held, clk_i, rst_ni,
              m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)

  `ASSERT_CLK(a_zero_outside, clk_i, rst_ni,
              m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == 32'd0)

  `ASSERT_CLK(a_ready_when_drained, clk_i, rst_ni, !m_axis_tvalid_o |-> s_axis_tready_o)

endmodule

bind gaussian_derivative_pulse_generator gdpg_checker u_gdpg_checker (.*);

`default_nettype wire

/* tb/sv/gaussian_derivative_pulse_generator_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gaussian_derivative_pulse_generator_test
// Streams sample times through the pulse generator under several window,
// delay, frequency and amplitude settings, and compares every wavelet value
// and window flag with a fixed-point prediction computed in the bench.
// ---------------------------------------------------------------------------

module gaussian_derivative_pulse_generator_test;

  localparam int              QFrac      = 16;
  localparam int              DecayDepth = 256;
  localparam longint unsigned OneQ30     = 64'd1 << 30;
  localparam longint unsigned PiQ30      = 64'd3373259426;
  localparam int              NumRegs    = 5;
  localparam int              Latency    = 8;
  localparam int              StallLimit = 2000;
  localparam int              ReportMax  = 50;

  typedef struct {
    logic [31:0] sample;
    logic [31:0] wave;
    logic        in_window;
  } wave_result_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b1;
  logic                                 s_axis_tvalid_i = 1'b0;
  logic                                 s_axis_tready_o;
  logic [gdpg_pkg::TimeW-1:0]           s_axis_tdata_i = '0;   // [31:0] sample_time
  logic                                 m_axis_tvalid_o;
  logic                                 m_axis_tready_i = 1'b0;
  logic signed [gdpg_pkg::OutW-1:0]     m_axis_tdata_o;        // [31:0] wave_value
  logic [0:0]                           m_axis_tuser_o;        // [0] in_window
  logic                                 cfg_valid_i = 1'b0;
  logic                                 cfg_ready_o;
  logic [gdpg_pkg::CfgIdxW-1:0]         cfg_index_i = '0;
  logic [gdpg_pkg::CfgDataW-1:0]        cfg_data_i = '0;

  logic [31:0]     amp_reg;
  logic [31:0]     win_start;
  logic [31:0]     win_finish;
  logic [31:0]     peak_offset;
  logic [23:0]     freq_hz;
  longint unsigned decay_tab [DecayDepth+1];

  wave_result_t    pending_waves [$];
  int              error_count = 0;
  int              burst_left = 0;
  int              idle_cycles = 0;
  logic [11:0]     stall_tick = '0;

  gaussian_derivative_pulse_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint unsigned rounded_shift(longint unsigned v, int s);
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic void build_decay_table();
    longint unsigned step;
    longint unsigned term;
    longint unsigned ratio;
    longint          acc;
    step = (64'd1 << 34) / DecayDepth;
    term = OneQ30;
    acc  = longint'(OneQ30);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * step) >> 30) / k;
      acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    ratio = (acc < 0) ? 64'd0 : unsigned'(acc);
    decay_tab[0] = OneQ30;
    for (int i = 1; i <= DecayDepth; i++) begin
      decay_tab[i] = rounded_shift(decay_tab[i-1] * ratio, 30);
    end
  endfunction

  function automatic wave_result_t predict_wave(logic [31:0] t);
    wave_result_t    res;
    longint unsigned origin;
    longint unsigned offset_mag;
    longint unsigned pf;
    longint unsigned umag;
    longint unsigned x;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned e;
    longint unsigned m;
    longint unsigned amag;
    longint unsigned ymag;
    logic            behind;
    logic            amp_neg;
    res.sample    = t;
    res.wave      = '0;
    res.in_window = 1'b0;
    if (t < win_start || t > win_finish) return res;
    res.in_window = 1'b1;
    origin     = 64'(win_start) + 64'(peak_offset);
    behind     = 64'(t) < origin;
    offset_mag = behind ? origin - 64'(t) : 64'(t) - origin;
    pf         = rounded_shift(PiQ30 * 64'(freq_hz), 30);
    umag       = rounded_shift(pf * offset_mag, QFrac);
    if (umag >= (64'd4 << QFrac)) return res;
    x = rounded_shift(umag * umag, QFrac);
    if (x >= (64'd16 << QFrac)) return res;
    pos  = x * DecayDepth;
    idx  = pos >> (QFrac + 4);
    frac = pos & ((64'd1 << (QFrac + 4)) - 1);
    if (idx >= DecayDepth) begin
      e = 0;
    end else begin
      e = decay_tab[idx] - (((decay_tab[idx] - decay_tab[idx+1]) * frac) >> (QFrac + 4));
    end
    m       = rounded_shift(umag * e, 30);
    amp_neg = amp_reg[31];
    amag    = amp_neg ? 64'h1_0000_0000 - 64'(amp_reg) : 64'(amp_reg);
    ymag    = rounded_shift(m * amag, QFrac);
    if (behind != amp_neg) begin
      if (ymag > 64'h8000_0000) ymag = 64'h8000_0000;
      res.wave = 32'(64'h1_0000_0000 - ymag);
    end else begin
      if (ymag > 64'h7FFF_FFFF) ymag = 64'h7FFF_FFFF;
      res.wave = ymag[31:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] near_peak_time();
    longint unsigned pf;
    longint unsigned span;
    longint unsigned origin;
    longint          spot;
    pf     = rounded_shift(PiQ30 * 64'(freq_hz), 30);
    span   = (pf == 0) ? 64'h1_0000 : (64'd1 << 34) / pf + 2;
    if (span > 64'h1_0000_0000) span = 64'h1_0000_0000;
    origin = 64'(win_start) + 64'(peak_offset);
    spot   = longint'(origin) + longint'({$urandom, $urandom} % (2 * span + 1))
             - longint'(span);
    if (spot < 0) return 32'd0;
    if (spot > longint'(64'hFFFF_FFFF)) return 32'hFFFF_FFFF;
    return spot[31:0];
  endfunction

  function automatic logic [31:0] random_sample_time();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        if (win_finish < win_start) return $urandom;
        return 32'(64'(win_start) +
                   {$urandom, $urandom} % (64'(win_finish) - 64'(win_start) + 1));
      end
      2: begin
        case ($urandom_range(0, 3))
          0: return win_start - 1;
          1: return win_start;
          2: return win_finish;
          default: return win_finish + 1;
        endcase
      end
      default: return near_peak_time();
    endcase
  endfunction

  // Sender: bursts of random length, random gaps between them.
  task automatic send_sample(input logic [31:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= t;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_waves.push_back(predict_wave(t));
  endtask

  task automatic wait_results();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_waves.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      gdpg_pkg::RegAmplitude:  amp_reg     = data;
      gdpg_pkg::RegStartTime:  win_start   = data;
      gdpg_pkg::RegFinishTime: win_finish  = data;
      gdpg_pkg::RegPeakDelay:  peak_offset = data;
      gdpg_pkg::RegFrequency:  freq_hz     = data[23:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [31:0] amp, input logic [31:0] start,
                              input logic [31:0] finish, input logic [31:0] peak,
                              input logic [31:0] freq);
    write_reg(gdpg_pkg::RegAmplitude, amp);
    write_reg(gdpg_pkg::RegStartTime, start);
    write_reg(gdpg_pkg::RegFinishTime, finish);
    write_reg(gdpg_pkg::RegPeakDelay, peak);
    write_reg(gdpg_pkg::RegFrequency, freq);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_random_config();
    logic [31:0] amp;
    logic [31:0] start;
    logic [31:0] finish;
    logic [31:0] peak;
    logic [31:0] len;
    logic [23:0] freq;
    case ($urandom_range(0, 5))
      0: amp = 32'h8000_0000;
      1: amp = 32'h7FFF_FFFF;
      2: amp = $urandom;
      3: amp = 32'h0001_0000;
      default: begin
        amp = $urandom_range(0, 32'h0008_0000);
        if ($urandom_range(0, 1)) amp = -amp;
      end
    endcase
    case ($urandom_range(0, 5))
      0: freq = 24'hFF_FFFF;
      1: freq = 24'($urandom);
      2: freq = 24'd0;
      default: freq = 24'($urandom_range(32'h100, 32'h8_0000));
    endcase
    start = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom;
    len   = $urandom_range(0, 32'h0100_0000);
    case ($urandom_range(0, 5))
      0: finish = 32'hFFFF_FFFF;
      1: begin
        start  = start | 32'h0010_0000;
        finish = start - $urandom_range(1, 32'h0010_0000);
      end
      default: finish = (64'(start) + 64'(len) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : start + len;
    endcase
    peak = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, len);
    apply_config(amp, start, finish, peak, {8'($urandom), freq});
  endtask

  task automatic test_reset_values();
    amp_reg     = 32'h0001_0000;
    win_start   = '0;
    win_finish  = '0;
    peak_offset = '0;
    freq_hz     = '0;
    send_sample(32'd0);
    send_sample(32'hFFFF_FFFF);
    wait_results();
  endtask

  task automatic test_window_edges();
    apply_config(32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 32'h0000_8000, 32'h0001_0000);
    send_sample(32'h0000_FFFF);
    send_sample(32'h0001_0000);
    send_sample(32'h0001_8000 - 32'd41000);
    send_sample(32'h0001_7FFF);
    send_sample(32'h0001_8000);
    send_sample(32'h0001_8001);
    send_sample(32'h0001_8000 + 32'd41000);
    send_sample(32'h0001_8000 + 32'd83443);
    send_sample(32'h0003_0000);
    send_sample(32'h0003_0001);
    wait_results();
  endtask

  task automatic test_unknown_index();
    for (int i = NumRegs; i < 8; i++) begin
      write_reg(3'(i), $urandom);
    end
    cfg_valid_i <= 1'b0;
    send_sample(32'h0001_4000);
    send_sample(32'h0002_0000);
    wait_results();
  endtask

  task automatic test_extremes();
    apply_config(32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_sample(32'd0);
    send_sample(32'd1);
    send_sample(32'd100);
    send_sample(32'hFFFF_FFFF);
    wait_results();
    apply_config(32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h00FF_FFFF);
    send_sample(32'h8000_0000 - 32'd50);
    send_sample(32'h8000_0000 + 32'd50);
    send_sample(32'h0000_0000);
    wait_results();
  endtask

  task automatic test_empty_window();
    apply_config(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'd0, 32'h0001_0000);
    send_sample(32'h0001_0000);
    send_sample(32'h0001_8000);
    send_sample(32'h0002_0000);
    wait_results();
  endtask

  task automatic test_drain_pause();
    apply_config(32'hFFFE_0000, 32'h0010_0000, 32'h0030_0000, 32'h0010_0000, 32'h0000_8000);
    repeat (10) send_sample(near_peak_time());
    wait_results();
    repeat (10) send_sample(near_peak_time());
    wait_results();
  endtask

  task automatic test_random_phases(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      apply_random_config();
      repeat (per_phase) send_sample(random_sample_time());
      wait_results();
    end
  endtask

  // Receiver: stall pattern is chosen by bits [11:9] of a free-running tick counter.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    case (stall_tick[11:9])
      3'd2: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      3'd3: m_axis_tready_i <= (stall_tick[2:0] != 3'd7);
      3'd4: m_axis_tready_i <= stall_tick[4];
      3'd5: m_axis_tready_i <= 1'($urandom_range(0, 1));
      3'd6: m_axis_tready_i <= (stall_tick[5:0] < 6'd8);
      default: m_axis_tready_i <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    wave_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_waves.size() == 0) begin
        error_count++;
        if (error_count <= ReportMax) begin
          $display("%0t: unexpected result: actual wave_value %0d in_window %0b",
                   $time, m_axis_tdata_o, m_axis_tuser_o[0]);
        end
      end else begin
        want = pending_waves.pop_front();
        if (m_axis_tdata_o !== want.wave) begin
          error_count++;
          if (error_count <= ReportMax) begin
            $display("%0t: wave_value mismatch, sample %h: expected %0d, actual %0d",
                     $time, want.sample, $signed(want.wave), m_axis_tdata_o);
          end
        end
        if (m_axis_tuser_o[0] !== want.in_window) begin
          error_count++;
          if (error_count <= ReportMax) begin
            $display("%0t: in_window mismatch, sample %h: expected %0b, actual %0b",
                     $time, want.sample, want.in_window, m_axis_tuser_o[0]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("** gaussian_derivative_pulse_generator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    build_decay_table();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_window_edges();
    test_unknown_index();
    test_extremes();
    test_empty_window();
    test_drain_pause();
    test_random_phases(23, 24);
    wait_results();
    repeat (2 * Latency) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** gaussian_derivative_pulse_generator: PASSED **");
    end else begin
      $display("** gaussian_derivative_pulse_generator: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/gdpg_pkg.sv
hw/rtl/gaussian_derivative_pulse_generator.sv
hw/rtl/gdpg_checker.sv
tb/sv/gaussian_derivative_pulse_generator_test.sv
